FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, opcodes, status codes, beat types and index helpers.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic               last_of_burst;
    logic [4:0]         occupancy;
  } out_t;

  // Fold a sum below twice the depth back into the ring.
  function automatic logic [PTR_W-1:0] wrap_pos(input logic [PTR_W:0] p);
    logic [PTR_W:0] d;
    d = p - (PTR_W + 1)'(DEPTH);
    return (p >= (PTR_W + 1)'(DEPTH)) ? d[PTR_W-1:0] : p[PTR_W-1:0];
  endfunction

  // Occupancy field carries the count masked to five bits.
  function automatic logic [4:0] occ5(input logic [CNT_W-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt);
    return w[4:0];
  endfunction

endpackage

FILE: rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Push, pop, dump and clear on a ring of entries held in one RAM.
// Results: push, clear, invalid and empty/full reports go straight into the output
//   register; a pop first reads the RAM (S_POP), then registers the item.
// Flow: one item at a time; a dump lists each entry by a RAM read (S_DRD),
//   then loads it into the output register (S_DWAIT) once that is free.
// Reset: synchronous; empties the deque, no clearing pass over the RAM.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_DRD   = 2'd2;
  localparam logic [1:0] S_DWAIT = 2'd3;

  logic [1:0]       state;
  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] dump_idx;

  logic             in_fire;
  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic             is_push;
  logic             is_pop;
  logic             in_waits;
  logic             out_load;
  logic [PTR_W-1:0] front_m1;
  logic [PTR_W-1:0] rear_push;
  logic [PTR_W-1:0] rear_pop;
  logic [PTR_W-1:0] dump_pos;
  logic [PTR_W-1:0] front_p1;
  logic [CNT_W-1:0] count_p1;
  logic [CNT_W-1:0] count_m1;
  logic             dump_last;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  always_comb begin
    out_free  = !out_valid || out_ready;
    in_ready  = (state == S_IDLE) && out_free;
    in_fire   = in_valid && in_ready;
    is_full   = (count == CNT_W'(DEPTH));
    is_empty  = (count == '0);
    is_push   = (in_data.opcode == OP_PUSH_FRONT) || (in_data.opcode == OP_PUSH_REAR);
    is_pop    = (in_data.opcode == OP_POP_FRONT) || (in_data.opcode == OP_POP_REAR);
    // pops and dumps of a non-empty deque answer only after a RAM read
    in_waits  = (is_pop || (in_data.opcode == OP_DUMP)) && !is_empty;
    out_load  = (in_fire && !in_waits) ||
                (((state == S_POP) || (state == S_DWAIT)) && out_free);
    count_p1  = count + 1'b1;
    count_m1  = count - 1'b1;
    front_m1  = (front == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(front - 1'b1);
    front_p1  = wrap_pos((PTR_W + 1)'(front) + 1'b1);
    rear_push = wrap_pos((PTR_W + 1)'(front) + (PTR_W + 1)'(count));
    rear_pop  = wrap_pos((PTR_W + 1)'(front) + (PTR_W + 1)'(count_m1));
    dump_pos  = wrap_pos((PTR_W + 1)'(front) + (PTR_W + 1)'(dump_idx));
    dump_last = (dump_idx == count_m1);

    ram_we    = in_fire && is_push && !is_full;
    ram_waddr = (in_data.opcode == OP_PUSH_FRONT) ? front_m1 : rear_push;
    ram_re    = (in_fire && is_pop && !is_empty) || (state == S_DRD);
    if (state == S_DRD) begin
      ram_raddr = dump_pos;
    end else if (in_data.opcode == OP_POP_FRONT) begin
      ram_raddr = front;
    end else begin
      ram_raddr = rear_pop;
    end
  end

  dq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            out_data.item_value    <= '0;
            out_data.last_of_burst <= 1'b1;
            unique case (in_data.opcode) inside
              OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (is_full) begin
                  out_data.status    <= ST_FULL;
                  out_data.occupancy <= occ5(count);
                end else begin
                  if (in_data.opcode == OP_PUSH_FRONT) begin
                    front <= front_m1;
                  end
                  count              <= count_p1;
                  out_data.status    <= ST_OK;
                  out_data.occupancy <= occ5(count_p1);
                end
              end
              OP_POP_FRONT, OP_POP_REAR: begin
                if (is_empty) begin
                  out_data.status    <= ST_EMPTY;
                  out_data.occupancy <= occ5(count);
                end else begin
                  // go to S_POP to wait for the RAM read
                  if (in_data.opcode == OP_POP_FRONT) begin
                    front <= front_p1;
                  end
                  count <= count_m1;
                  state <= S_POP;
                end
              end
              OP_DUMP: begin
                if (is_empty) begin
                  out_data.status    <= ST_EMPTY;
                  out_data.occupancy <= occ5(count);
                end else begin
                  dump_idx <= '0;
                  state    <= S_DRD;
                end
              end
              OP_CLEAR: begin
                front              <= '0;
                count              <= '0;
                out_data.status    <= ST_OK;
                out_data.occupancy <= 5'd0;
              end
              default: begin
                out_data.status    <= ST_INVALID;
                out_data.occupancy <= occ5(count);
              end
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            out_data.status        <= ST_OK;
            out_data.item_value    <= ram_rdata;
            out_data.last_of_burst <= 1'b1;
            out_data.occupancy     <= occ5(count);
            state                  <= S_IDLE;
          end
        end
        S_DRD: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          // hold the read data until the output register frees up
          if (out_free) begin
            out_data.status        <= ST_OK;
            out_data.item_value    <= ram_rdata;
            out_data.last_of_burst <= dump_last;
            out_data.occupancy     <= occ5(count);
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              dump_idx <= dump_idx + 1'b1;
              state    <= S_DRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/dq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches both channels of the deque, keeps its own ring of entries, works out
// the result beats of every accepted command and compares each output beat
// field by field with the oldest beat still awaited.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   awaiting,
  output int   beats_checked
);

  logic signed [31:0] ring [DEPTH];
  int                 head_pos;
  int                 live_count;
  out_t               awaited_beats [$];
  int                 err_total = 0;
  int                 seen_total = 0;

  function automatic out_t make_beat(logic [1:0] st, logic signed [31:0] value,
                                     logic last, int occ);
    out_t b;
    b.status        = st;
    b.item_value    = value;
    b.last_of_burst = last;
    b.occupancy     = occ[4:0];
    return b;
  endfunction

  // Update the shadow deque and queue up the beats this command produces.
  task automatic apply_cmd(in_t cmd);
    int                 pos;
    logic signed [31:0] value;
    case (cmd.opcode) inside
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (live_count >= DEPTH) begin
          awaited_beats.push_back(make_beat(ST_FULL, '0, 1'b1, live_count));
        end else begin
          if (cmd.opcode == OP_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            ring[head_pos] = cmd.push_value;
          end else begin
            ring[(head_pos + live_count) % DEPTH] = cmd.push_value;
          end
          live_count++;
          awaited_beats.push_back(make_beat(ST_OK, '0, 1'b1, live_count));
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (live_count == 0) begin
          awaited_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1, live_count));
        end else begin
          if (cmd.opcode == OP_POP_FRONT) begin
            value    = ring[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            value = ring[(head_pos + live_count - 1) % DEPTH];
          end
          live_count--;
          awaited_beats.push_back(make_beat(ST_OK, value, 1'b1, live_count));
        end
      end
      OP_DUMP: begin
        if (live_count == 0) begin
          awaited_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1, live_count));
        end else begin
          for (int i = 0; i < live_count; i++) begin
            pos = (head_pos + i) % DEPTH;
            awaited_beats.push_back(make_beat(ST_OK, ring[pos], i == live_count - 1,
                                              live_count));
          end
        end
      end
      OP_CLEAR: begin
        head_pos   = 0;
        live_count = 0;
        awaited_beats.push_back(make_beat(ST_OK, '0, 1'b1, 0));
      end
      default: begin
        awaited_beats.push_back(make_beat(ST_INVALID, '0, 1'b1, live_count));
      end
    endcase
  endtask

  task automatic compare_beat(out_t got);
    out_t want;
    seen_total++;
    if (awaited_beats.size() == 0) begin
      $display("%0t: unexpected result beat status %0d value %0d last %0d occ %0d",
               $time, got.status, got.item_value, got.last_of_burst, got.occupancy);
      err_total++;
    end else begin
      want = awaited_beats.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        err_total++;
      end
      if (got.item_value !== want.item_value) begin
        $display("%0t: item_value expected %0d got %0d", $time,
                 want.item_value, got.item_value);
        err_total++;
      end
      if (got.last_of_burst !== want.last_of_burst) begin
        $display("%0t: last_of_burst expected %0d got %0d", $time,
                 want.last_of_burst, got.last_of_burst);
        err_total++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t: occupancy expected %0d got %0d", $time,
                 want.occupancy, got.occupancy);
        err_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_pos   = 0;
      live_count = 0;
      awaited_beats.delete();
    end else begin
      if (in_valid && in_ready) apply_cmd(in_data);
      if (out_valid && out_ready) compare_beat(out_data);
    end
    mismatches    <= err_total;
    awaiting      <= awaited_beats.size();
    beats_checked <= seen_total;
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and random deque commands in bursts with random gaps,
// stalls the result side on shifting patterns plus one long hold-off, and
// takes the verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  localparam logic [2:0] OP_BAD_6 = 3'd6;
  localparam logic [2:0] OP_BAD_7 = 3'd7;

  localparam int LEAN_FILL  = 0;
  localparam int LEAN_DRAIN = 1;
  localparam int LEAN_MIX   = 2;

  localparam int RX_FREE   = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int RX_PERIOD = 3;

  localparam int RANDOM_OPS  = 280;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int mismatches;
  int awaiting;
  int beats_checked;
  int ops_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  double_ended_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  dq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .beats_checked(beats_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int lean);
    int r;
    int push_cut;
    int pop_cut;
    r = $urandom_range(0, 99);
    case (lean)
      LEAN_FILL: begin
        push_cut = 70;
        pop_cut  = 85;
      end
      LEAN_DRAIN: begin
        push_cut = 25;
        pop_cut  = 85;
      end
      default: begin
        push_cut = 45;
        pop_cut  = 85;
      end
    endcase
    if (r < push_cut) return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    if (r < pop_cut) return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
    if (r < 94) return OP_DUMP;
    if (r < 96) return (lean == LEAN_MIX) ? OP_CLEAR : OP_DUMP;
    return $urandom_range(0, 1) ? OP_BAD_7 : OP_BAD_6;
  endfunction

  // Offer one command beat; open a new burst after a random gap when due.
  task automatic send_op(logic [2:0] op, logic signed [31:0] value);
    in_t beat;
    int  gap;
    beat.opcode     = op;
    beat.push_value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
  endtask

  // Result side: shifting stall patterns, plus one long hold-off on request.
  initial begin : result_side
    int mode;
    int tick;
    mode = RX_FREE;
    tick = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (tick % 64 == 0) mode = $urandom_range(RX_FREE, RX_PERIOD);
        tick++;
        case (mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready <= ($urandom_range(0, 2) == 0);
          default:  out_ready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[double_ended_queue] ERROR");
    $finish;
  end

  initial begin : stimulus
    int lean;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty deque, invalid codes, extreme values at both ends.
    send_op(OP_POP_FRONT, 32'sd0);
    send_op(OP_POP_REAR, -32'sd1);
    send_op(OP_DUMP, 32'sh5555_5555);
    send_op(OP_BAD_6, 32'sh2aaa_aaaa);
    send_op(OP_BAD_7, -32'sd1);
    send_op(OP_PUSH_FRONT, 32'sh8000_0000);
    send_op(OP_PUSH_REAR, 32'sh7fff_ffff);
    send_op(OP_PUSH_FRONT, -32'sd1);
    send_op(OP_PUSH_REAR, 32'sd0);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_POP_FRONT, 32'sd0);
    send_op(OP_POP_REAR, 32'sd0);
    // Fill to capacity, then push into a full deque at each end.
    for (int k = 0; k < DEPTH - 2; k++) begin
      send_op(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, rand_value());
    end
    send_op(OP_PUSH_FRONT, 32'sh1234_5678);
    send_op(OP_PUSH_REAR, -32'sd2);
    send_op(OP_DUMP, 32'sd0);
    send_op(OP_CLEAR, 32'sd0);

    lean = LEAN_FILL;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 0) begin
        hold_req = 1'b1;
      end else if (n % 40 == 0) begin
        lean = $urandom_range(LEAN_FILL, LEAN_MIX);
      end
      send_op(pick_op(lean), rand_value());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d commands and %0d result beats, with bursty input,",
             ops_sent, beats_checked);
    $display("shifting output stalls and one %0d-cycle output hold-off.", LONG_HOLD);
    if (mismatches == 0 && awaiting == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
test/dq_checker.sv
test/tb_top.sv
